### rtl/tgd_pkg.sv
// Shared types and constants for the three-button gesture detector.
`default_nettype none

package tgd_pkg;

   // thresholds are held in microseconds: 65535 ms * 1000 fits in 26 bits
   localparam int unsigned THR_W     = 26;
   localparam int unsigned MS_W      = 16;
   localparam int unsigned US_PER_MS = 1000;
   localparam int unsigned BTN_COUNT = 3;
   localparam int unsigned RSP_W     = 8;

   localparam logic [THR_W-1:0] DEBOUNCE_RST     = THR_W'(20 * 1000);
   localparam logic [THR_W-1:0] POWER_LONG_RST   = THR_W'(3000 * 1000);
   localparam logic [THR_W-1:0] SHUTTER_LONG_RST = THR_W'(1000 * 1000);
   localparam logic [THR_W-1:0] DOUBLE_TAP_RST   = THR_W'(600 * 1000);

   typedef enum logic [1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_POWER_LONG   = 2'd1,
      CSR_SHUTTER_LONG = 2'd2,
      CSR_DOUBLE_TAP   = 2'd3
   } csr_idx_type;

   // button order inside every per-button vector
   localparam int unsigned BTN_POWER   = 0;
   localparam int unsigned BTN_SHUTTER = 1;
   localparam int unsigned BTN_AI      = 2;

   typedef struct packed {
      logic changed;   // settled level changes on this tick
      logic level;     // new level, valid with changed
   } btn_event_type;

   typedef struct packed {
      logic ai_double_tap;
      logic shutter_long_press;
      logic shutter_click;
      logic power_long_press;
   } gesture_type;

   typedef struct packed {
      logic [THR_W-1:0] power_long;
      logic [THR_W-1:0] shutter_long;
      logic [THR_W-1:0] double_tap;
   } gesture_thr_type;

endpackage

`default_nettype wire

### rtl/tgd_debounce.sv
// Debounce of one button: raw level tracking, change time and settled level.
`default_nettype none

module tgd_debounce #(
   parameter int unsigned TIME_BITS = 48
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [TIME_BITS-1:0]     now,
   input  wire logic                     raw,
   input  wire logic [tgd_pkg::THR_W-1:0] thr,
   output tgd_pkg::btn_event_type        evt
);

   logic                 raw_seen_ff, raw_seen_in;
   logic                 settled_ff, settled_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic                 raw_new;
   logic [TIME_BITS-1:0] since;
   logic                 held;

   assign raw_new = raw != raw_seen_ff;
   // a fresh raw change has zero elapsed time
   assign since   = raw_new ? '0 : now - change_time_ff;
   assign held    = since >= {{(TIME_BITS - tgd_pkg::THR_W){1'b0}}, thr};

   assign evt.changed = held && (raw != settled_ff);
   assign evt.level   = raw;

   always_comb begin
      raw_seen_in    = raw_seen_ff;
      settled_in     = settled_ff;
      change_time_in = change_time_ff;
      if (step) begin
         raw_seen_in = raw;
         if (raw_new) begin
            change_time_in = now;
         end
         if (evt.changed) begin
            settled_in = raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff <= 1'b0;
         settled_ff  <= 1'b0;
      end else begin
         raw_seen_ff <= raw_seen_in;
         settled_ff  <= settled_in;
      end
      change_time_ff <= change_time_in;
   end

endmodule

`default_nettype wire

### rtl/tgd_gesture.sv
// Press timing for power and shutter, double tap tracking for the AI button.
`default_nettype none

module tgd_gesture #(
   parameter int unsigned TIME_BITS = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [TIME_BITS-1:0]        now,
   input  wire logic                        powered,
   input  wire tgd_pkg::btn_event_type      btn [tgd_pkg::BTN_COUNT],
   input  wire tgd_pkg::gesture_thr_type    thr,
   output tgd_pkg::gesture_type             gest
);

   localparam int unsigned PAD = TIME_BITS - tgd_pkg::THR_W;

   logic [TIME_BITS-1:0] press_time_ff [2];
   logic [TIME_BITS-1:0] press_time_in [2];
   logic [1:0]           press_valid_ff, press_valid_in;
   logic                 tap_pending_ff, tap_pending_in;
   logic [TIME_BITS-1:0] tap_time_ff, tap_time_in;

   logic [TIME_BITS-1:0] long_thr [2];
   logic [1:0]           release_seen;
   logic [1:0]           held_long;
   logic                 ai_release;
   logic                 tap_expired;
   logic                 dtap;

   assign long_thr[0] = {{PAD{1'b0}}, thr.power_long};
   assign long_thr[1] = {{PAD{1'b0}}, thr.shutter_long};

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         release_seen[i] = btn[i].changed && !btn[i].level && press_valid_ff[i];
         held_long[i]    = (now - press_time_ff[i]) >= long_thr[i];
      end
   end

   assign ai_release  = btn[tgd_pkg::BTN_AI].changed && !btn[tgd_pkg::BTN_AI].level
                        && powered;
   assign tap_expired = (now - tap_time_ff) > {{PAD{1'b0}}, thr.double_tap};
   assign dtap        = ai_release && tap_pending_ff && !tap_expired;

   assign gest.power_long_press   = release_seen[tgd_pkg::BTN_POWER]
                                    && held_long[tgd_pkg::BTN_POWER];
   assign gest.shutter_long_press = release_seen[tgd_pkg::BTN_SHUTTER]
                                    && held_long[tgd_pkg::BTN_SHUTTER];
   assign gest.shutter_click      = release_seen[tgd_pkg::BTN_SHUTTER]
                                    && !held_long[tgd_pkg::BTN_SHUTTER];
   assign gest.ai_double_tap      = dtap;

   always_comb begin
      press_valid_in = press_valid_ff;
      tap_pending_in = tap_pending_ff;
      tap_time_in    = tap_time_ff;
      for (int i = 0; i < 2; i++) begin
         press_time_in[i] = press_time_ff[i];
         if (step && btn[i].changed) begin
            if (btn[i].level) begin
               press_time_in[i]  = now;
               press_valid_in[i] = 1'b1;
            end else begin
               press_valid_in[i] = 1'b0;
            end
         end
      end
      if (step && ai_release) begin
         if (dtap) begin
            tap_pending_in = 1'b0;
         end else begin
            // first release, or the window ran out: start a new sequence
            tap_pending_in = 1'b1;
            tap_time_in    = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_valid_ff <= '0;
         tap_pending_ff <= 1'b0;
      end else begin
         press_valid_ff <= press_valid_in;
         tap_pending_ff <= tap_pending_in;
      end
      press_time_ff <= press_time_in;
      tap_time_ff   <= tap_time_in;
   end

endmodule

`default_nettype wire

### rtl/three_button_gesture_detector.sv
// Top level of the three-button gesture detector: handshakes, CSRs, input and result registers.
//
//  channel | direction | transaction
//  req_    | in        | one scan tick: timestamp, three raw levels, powered flag
//  rsp_    | out       | one result per tick: activity and four gesture flags
//  csr_    | in        | threshold write in milliseconds, no read-back
//
// A tick is taken into the input register, evaluated combinationally and lands in the
// result register; one tick per clock is sustained while rsp_tready is high.
// The input register keeps accepting while a result waits, until it holds one itself.
// Thresholds are converted to microseconds when written, so they apply to the next tick.
// Synchronous reset clears levels, press and tap flags and the thresholds to defaults.
`default_nettype none

module three_button_gesture_detector #(
   parameter int unsigned TIME_BITS = 48
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output wire logic                             req_tready,
   // now_us, power_pressed, shutter_pressed, ai_pressed, device_powered, zero pad
   input  wire logic [((TIME_BITS+4+7)/8)*8-1:0] req_tdata,
   output wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // activity, power_long_press, shutter_click, shutter_long_press, ai_double_tap, zero pad
   output wire logic [tgd_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_addr,
   input  wire logic [tgd_pkg::MS_W-1:0]         csr_wdata
);

   localparam int unsigned THR_W = tgd_pkg::THR_W;

   logic                 in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0] now_ff;
   logic [2:0]           raw_ff;
   logic                 powered_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [4:0]           rsp_ff;

   logic [THR_W-1:0]     debounce_thr_ff;
   tgd_pkg::gesture_thr_type thr_ff;
   logic [THR_W-1:0]     csr_us;

   logic                 step;
   logic                 accept;
   logic                 activity;
   tgd_pkg::btn_event_type btn [tgd_pkg::BTN_COUNT];
   tgd_pkg::gesture_type   gest;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         now_ff     <= req_tdata[TIME_BITS-1:0];
         raw_ff     <= req_tdata[TIME_BITS+2:TIME_BITS];
         powered_ff <= req_tdata[TIME_BITS+3];
      end
      if (step) begin
         rsp_ff <= {gest.ai_double_tap, gest.shutter_long_press, gest.shutter_click,
                    gest.power_long_press, activity};
      end
   end

   // ms to us at write time
   assign csr_us = THR_W'(csr_wdata) * THR_W'(tgd_pkg::US_PER_MS);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_thr_ff     <= tgd_pkg::DEBOUNCE_RST;
         thr_ff.power_long   <= tgd_pkg::POWER_LONG_RST;
         thr_ff.shutter_long <= tgd_pkg::SHUTTER_LONG_RST;
         thr_ff.double_tap   <= tgd_pkg::DOUBLE_TAP_RST;
      end else if (csr_we) begin
         case (tgd_pkg::csr_idx_type'(csr_addr))
            tgd_pkg::CSR_DEBOUNCE:     debounce_thr_ff     <= csr_us;
            tgd_pkg::CSR_POWER_LONG:   thr_ff.power_long   <= csr_us;
            tgd_pkg::CSR_SHUTTER_LONG: thr_ff.shutter_long <= csr_us;
            tgd_pkg::CSR_DOUBLE_TAP:   thr_ff.double_tap   <= csr_us;
            default: ;
         endcase
      end
   end

   for (genvar b = 0; b < tgd_pkg::BTN_COUNT; b++) begin : g_btn
      tgd_debounce #(
         .TIME_BITS (TIME_BITS)
      ) u_debounce (
         .clock (clock),
         .reset (reset),
         .step  (step),
         .now   (now_ff),
         .raw   (raw_ff[b]),
         .thr   (debounce_thr_ff),
         .evt   (btn[b])
      );
   end

   assign activity = btn[tgd_pkg::BTN_POWER].changed || btn[tgd_pkg::BTN_SHUTTER].changed
                     || btn[tgd_pkg::BTN_AI].changed;

   tgd_gesture #(
      .TIME_BITS (TIME_BITS)
   ) u_gesture (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .now     (now_ff),
      .powered (powered_ff),
      .btn     (btn),
      .thr     (thr_ff),
      .gest    (gest)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tgd_pkg::RSP_W - 5){1'b0}}, rsp_ff};

endmodule

`default_nettype wire

### rtl/tgd_checker.sv
// Port-level checks for the three-button gesture detector, bound to the top level.
`default_nettype none

module tgd_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [tgd_pkg::RSP_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every gesture comes from a settled change
   a_gesture_activity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:1] != 4'b0) |-> rsp_tdata[0])
      else $error("gesture without activity");

   // a shutter release is either a click or a long press
   a_shutter_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("shutter click and long press together");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[tgd_pkg::RSP_W-1:5] == '0)
      else $error("result pad bits not zero");

endmodule

bind three_button_gesture_detector tgd_checker u_tgd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/tb_three_button_gesture_detector.sv
// Self-checking testbench for the three-button gesture detector.
`timescale 1ns / 100ps

module tb_three_button_gesture_detector;

   localparam int unsigned TIME_W     = 48;
   localparam int unsigned REQ_W      = ((TIME_W + 4 + 7) / 8) * 8;
   localparam int unsigned MAX_CYCLES = 200000;
   localparam int unsigned DRAIN_WAIT = 8;
   localparam int unsigned MAX_REPORT = 10;

   typedef struct packed {
      logic              device_powered;
      logic              ai_pressed;
      logic              shutter_pressed;
      logic              power_pressed;
      logic [TIME_W-1:0] now_us;
   } scan_tick_type;

   typedef struct packed {
      logic ai_double_tap;
      logic shutter_long_press;
      logic shutter_click;
      logic power_long_press;
      logic activity;
   } gesture_flags_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_SHORT,
      HOLD_LONG
   } hold_kind_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   wire                        req_tready;
   logic [REQ_W-1:0]           req_tdata = '0;
   wire                        rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   wire  [tgd_pkg::RSP_W-1:0]  rsp_tdata;
   logic                       csr_we = 1'b0;
   logic [1:0]                 csr_addr = '0;
   logic [tgd_pkg::MS_W-1:0]   csr_wdata = '0;

   three_button_gesture_detector #(
      .TIME_BITS (TIME_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- gesture predictor state ----------------
   logic [tgd_pkg::MS_W-1:0] cfg_ms [4];
   logic              raw_last     [tgd_pkg::BTN_COUNT];
   logic              level_now    [tgd_pkg::BTN_COUNT];
   logic [TIME_W-1:0] raw_change_t [tgd_pkg::BTN_COUNT];
   logic [TIME_W-1:0] press_t      [2];
   logic              press_seen   [2];
   logic              tap_armed;
   logic [TIME_W-1:0] tap_t;
   logic              tap_t_ok;

   scan_tick_type     pending_ticks [$];
   gesture_flags_type expected_flags [$];
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;
   logic [TIME_W-1:0] tnow;
   logic              want_level [tgd_pkg::BTN_COUNT];
   logic              want_powered;

   string flag_names [5] = '{"activity", "power_long_press", "shutter_click",
                             "shutter_long_press", "ai_double_tap"};

   function automatic logic [63:0] thr_us(tgd_pkg::csr_idx_type idx);
      return 64'(cfg_ms[idx]) * 64'(tgd_pkg::US_PER_MS);
   endfunction

   // debounce one button, returns 1 when its settled level flips
   function automatic logic settle_button(int b, logic raw, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] dt;
      if (raw != raw_last[b]) begin
         raw_last[b]     = raw;
         raw_change_t[b] = now;
      end
      dt = now - raw_change_t[b];
      if (64'(dt) < thr_us(tgd_pkg::CSR_DEBOUNCE)) return 1'b0;
      if (raw == level_now[b]) return 1'b0;
      level_now[b] = raw;
      return 1'b1;
   endfunction

   function automatic hold_kind_type hold_class(int b, logic raw, logic [TIME_W-1:0] now,
                                                logic [63:0] long_us);
      logic [TIME_W-1:0] held;
      if (raw) begin
         press_t[b]    = now;
         press_seen[b] = 1'b1;
         return HOLD_NONE;
      end
      if (!press_seen[b]) return HOLD_NONE;
      held          = now - press_t[b];
      press_seen[b] = 1'b0;
      return (64'(held) >= long_us) ? HOLD_LONG : HOLD_SHORT;
   endfunction

   function automatic logic ai_tap(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] gap;
      gap = now - tap_t;
      if (tap_t_ok && 64'(gap) > thr_us(tgd_pkg::CSR_DOUBLE_TAP)) tap_armed = 1'b0;
      if (tap_armed) begin
         tap_armed = 1'b0;
         tap_t     = '0;
         tap_t_ok  = 1'b0;
         return 1'b1;
      end
      tap_armed = 1'b1;
      tap_t     = now;
      tap_t_ok  = 1'b1;
      return 1'b0;
   endfunction

   function automatic gesture_flags_type gesture_predict(scan_tick_type s);
      gesture_flags_type f;
      hold_kind_type     h;
      f = '0;
      if (settle_button(tgd_pkg::BTN_POWER, s.power_pressed, s.now_us)) begin
         f.activity = 1'b1;
         h = hold_class(tgd_pkg::BTN_POWER, s.power_pressed, s.now_us,
                        thr_us(tgd_pkg::CSR_POWER_LONG));
         f.power_long_press = (h == HOLD_LONG);
      end
      if (settle_button(tgd_pkg::BTN_SHUTTER, s.shutter_pressed, s.now_us)) begin
         f.activity = 1'b1;
         h = hold_class(tgd_pkg::BTN_SHUTTER, s.shutter_pressed, s.now_us,
                        thr_us(tgd_pkg::CSR_SHUTTER_LONG));
         f.shutter_long_press = (h == HOLD_LONG);
         f.shutter_click      = (h == HOLD_SHORT);
      end
      if (settle_button(tgd_pkg::BTN_AI, s.ai_pressed, s.now_us)) begin
         f.activity = 1'b1;
         // unpowered: level still moves, tap sequence is left alone
         if (s.device_powered && !s.ai_pressed) f.ai_double_tap = ai_tap(s.now_us);
      end
      return f;
   endfunction

   initial begin
      cfg_ms[tgd_pkg::CSR_DEBOUNCE]     = 16'd20;
      cfg_ms[tgd_pkg::CSR_POWER_LONG]   = 16'd3000;
      cfg_ms[tgd_pkg::CSR_SHUTTER_LONG] = 16'd1000;
      cfg_ms[tgd_pkg::CSR_DOUBLE_TAP]   = 16'd600;
      for (int i = 0; i < tgd_pkg::BTN_COUNT; i++) begin
         raw_last[i]     = 1'b0;
         level_now[i]    = 1'b0;
         raw_change_t[i] = '0;
         want_level[i]   = 1'b0;
      end
      for (int i = 0; i < 2; i++) begin
         press_t[i]    = '0;
         press_seen[i] = 1'b0;
      end
      tap_armed    = 1'b0;
      tap_t        = '0;
      tap_t_ok     = 1'b0;
      want_powered = 1'b1;
   end

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_flags.push_back(
               gesture_predict(scan_tick_type'(req_tdata[TIME_W+3:0])));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= REQ_W'(pending_ticks.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      gesture_flags_type want;
      gesture_flags_type got;
      logic              bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = gesture_flags_type'(rsp_tdata[4:0]);
            if (expected_flags.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("[%0t] unexpected result transaction %b", $realtime, got);
            end else begin
               want = expected_flags.pop_front();
               bad  = 1'b0;
               for (int f = 0; f < 5; f++) begin
                  if (got[f] !== want[f]) begin
                     bad = 1'b1;
                     if (mismatches < MAX_REPORT)
                        $display("[%0t] %s: expected %b, got %b", $realtime,
                                 flag_names[f], want[f], got[f]);
                  end
               end
               if (bad) mismatches++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_tick(logic [TIME_W-1:0] t, logic pw, logic sh, logic ai, logic on);
      scan_tick_type s;
      s.now_us          = t;
      s.power_pressed   = pw;
      s.shutter_pressed = sh;
      s.ai_pressed      = ai;
      s.device_powered  = on;
      pending_ticks.push_back(s);
   endtask

   task automatic add_random_ticks(int n);
      logic [63:0] span;
      logic [63:0] db;
      logic        raw [tgd_pkg::BTN_COUNT];
      int unsigned r;
      db   = thr_us(tgd_pkg::CSR_DEBOUNCE);
      span = thr_us(tgd_pkg::CSR_POWER_LONG);
      if (thr_us(tgd_pkg::CSR_SHUTTER_LONG) > span) span = thr_us(tgd_pkg::CSR_SHUTTER_LONG);
      if (thr_us(tgd_pkg::CSR_DOUBLE_TAP) > span) span = thr_us(tgd_pkg::CSR_DOUBLE_TAP);
      span = 2 * span + 1000;
      for (int k = 0; k < n; k++) begin
         for (int b = 0; b < tgd_pkg::BTN_COUNT; b++) begin
            if ($urandom_range(99) < 15) want_level[b] = !want_level[b];
            // short glitch against the intended level
            raw[b] = want_level[b] ^ ($urandom_range(99) < 6);
         end
         if ($urandom_range(99) < 5) want_powered = !want_powered;
         add_tick(tnow, raw[tgd_pkg::BTN_POWER], raw[tgd_pkg::BTN_SHUTTER],
                  raw[tgd_pkg::BTN_AI], want_powered);
         r = $urandom_range(99);
         if (r < 40)      tnow = tnow + TIME_W'($urandom_range(0, 32'(db + 2000)));
         else if (r < 85) tnow = tnow + TIME_W'($urandom_range(0, 32'(span)));
         else if (r < 95) tnow = tnow;
         else             tnow = TIME_W'({$urandom, $urandom});
      end
   endtask

   task automatic csr_write(tgd_pkg::csr_idx_type idx, logic [tgd_pkg::MS_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      cfg_ms[idx] = val;
   endtask

   task automatic configure(logic [tgd_pkg::MS_W-1:0] db, logic [tgd_pkg::MS_W-1:0] pl,
                            logic [tgd_pkg::MS_W-1:0] sl, logic [tgd_pkg::MS_W-1:0] dt);
      csr_write(tgd_pkg::CSR_DEBOUNCE, db);
      csr_write(tgd_pkg::CSR_POWER_LONG, pl);
      csr_write(tgd_pkg::CSR_SHUTTER_LONG, sl);
      csr_write(tgd_pkg::CSR_DOUBLE_TAP, dt);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idle(idle_mode_type m);
      case (m)
         IDLE_NONE: begin
            send_idle_pct = 0;  recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 74; recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;  recv_stall_pct = 74;
         end
         default: begin
            send_idle_pct = 13; recv_stall_pct = 13;
         end
      endcase
   endtask

   // sender holds off until every expected result is back
   task automatic drain();
      @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_flags.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset thresholds: 20 ms debounce, 3 s / 1 s long, 600 ms tap window
      set_idle(IDLE_NONE);
      add_tick(48'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_tick(48'd1000, 1'b1, 1'b0, 1'b0, 1'b1);       // power raw press
      add_tick(48'd10000, 1'b0, 1'b0, 1'b0, 1'b1);      // bounce back before settling
      add_tick(48'd15000, 1'b1, 1'b0, 1'b0, 1'b1);
      add_tick(48'd35000, 1'b1, 1'b0, 1'b0, 1'b1);      // press settles
      add_tick(48'd3100000, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(48'd3120000, 1'b0, 1'b1, 1'b0, 1'b1);    // power long release
      add_tick(48'd3140000, 1'b0, 1'b1, 1'b0, 1'b1);
      add_tick(48'd3500000, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(48'd3520000, 1'b0, 1'b0, 1'b0, 1'b1);    // shutter click
      add_tick(48'd4000000, 1'b0, 1'b1, 1'b1, 1'b1);
      add_tick(48'd4020000, 1'b0, 1'b1, 1'b1, 1'b1);    // settles at exactly the debounce time
      add_tick(48'd5000000, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(48'd5020000, 1'b0, 1'b0, 1'b0, 1'b1);    // shutter long at threshold, first tap
      add_tick(48'd5100000, 1'b0, 1'b0, 1'b1, 1'b1);
      add_tick(48'd5120000, 1'b0, 1'b0, 1'b1, 1'b1);
      add_tick(48'd5600000, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(48'd5620000, 1'b0, 1'b0, 1'b0, 1'b1);    // double tap at window edge
      add_tick(48'd6000000, 1'b0, 1'b0, 1'b1, 1'b0);
      add_tick(48'd6020000, 1'b0, 1'b0, 1'b1, 1'b0);
      add_tick(48'd6100000, 1'b0, 1'b0, 1'b0, 1'b0);
      add_tick(48'd6120000, 1'b0, 1'b0, 1'b0, 1'b0);    // AI release unpowered
      add_tick(48'hFFFF_FFFF_F000, 1'b1, 1'b0, 1'b0, 1'b1);
      add_tick(48'h0000_0000_4000, 1'b1, 1'b0, 1'b0, 1'b1); // settles across the wrap
      add_tick(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      tnow = 48'h0000_0010_0000;
      add_random_ticks(50);
      drain();

      configure(16'd2, 16'd15, 16'd8, 16'd10);
      set_idle(IDLE_SENDER);
      add_random_ticks(65);
      drain();

      configure(16'd0, 16'd0, 16'd0, 16'd0);
      set_idle(IDLE_RECEIVER);
      add_random_ticks(65);
      drain();

      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_idle(IDLE_BOTH);
      add_random_ticks(65);
      drain();

      configure(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      set_idle(IDLE_NONE);
      add_random_ticks(65);
      drain();

      configure(tgd_pkg::MS_W'($urandom_range(0, 50)), tgd_pkg::MS_W'($urandom_range(0, 50)),
                tgd_pkg::MS_W'($urandom_range(0, 50)), tgd_pkg::MS_W'($urandom_range(0, 50)));
      set_idle(IDLE_SENDER);
      add_random_ticks(35);
      drain();
      set_idle(IDLE_BOTH);
      add_random_ticks(35);
      drain();

      if (mismatches == 0 && expected_flags.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("mismatches: %0d, results still expected: %0d",
                  mismatches, expected_flags.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/tgd_pkg.sv
rtl/tgd_debounce.sv
rtl/tgd_gesture.sv
rtl/three_button_gesture_detector.sv
rtl/tgd_checker.sv
tb/tb_three_button_gesture_detector.sv
